// ----- rtl/bfst_pkg.sv -----
// ----------------------------------------------------------------------------
// bfst_pkg
// shared types and constants for the bidirectional flow statistics table
// ----------------------------------------------------------------------------
package bfst_pkg;

  localparam int unsigned FlowEntries = 64;
  localparam int unsigned IdxW = $clog2(FlowEntries);
  localparam int unsigned CntW = $clog2(FlowEntries + 1);

  localparam int unsigned TsW   = 52;
  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned PayW  = 16;
  localparam int unsigned PktW  = 32;
  localparam int unsigned ByteW = 48;
  localparam int unsigned KeyW  = 2 * AddrW + 2 * PortW;
  localparam int unsigned OutIdxW = 6;

  // input beat: ts, src, dst, sport, dport, udp, payload = 165 bits -> 168
  localparam int unsigned InDataW  = 168;
  // output beat: 6+1+1+1+1+52+52+32+48+32+48 = 274 bits -> 280
  localparam int unsigned OutDataW = 280;

  // counters and times kept per entry
  typedef struct packed {
    logic             udp;
    logic [TsW-1:0]   start;
    logic [TsW-1:0]   dur;
    logic [PktW-1:0]  fpk;
    logic [ByteW-1:0] fby;
    logic [PktW-1:0]  rpk;
    logic [ByteW-1:0] rby;
  } stats_t;

  // lookup outcome passed from match unit to update stage
  typedef struct packed {
    logic            hit;
    logic            rev;
    logic [IdxW-1:0] idx;
  } match_t;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StOut
  } state_e;

endpackage

// ----- rtl/bfst_match.sv -----
// ----------------------------------------------------------------------------
// bfst_match
// key store with parallel forward and reverse compare over all entries
// ----------------------------------------------------------------------------
module bfst_match (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [bfst_pkg::KeyW-1:0] key_i,
  input  logic [bfst_pkg::KeyW-1:0] rkey_i,
  input  logic                    wr_i,
  input  logic [bfst_pkg::IdxW-1:0] wr_idx_i,
  output bfst_pkg::match_t        match_o
);
  import bfst_pkg::*;

  logic [FlowEntries-1:0] valid_q;
  logic [KeyW-1:0]        key_q [FlowEntries];
  logic [FlowEntries-1:0] fhit, rhit;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // key registers
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q[wr_idx_i] <= key_i;
    end
  end

  // compare lanes
  always_comb begin
    for (int i = 0; i < FlowEntries; i++) begin
      fhit[i] = valid_q[i] && (key_q[i] == key_i);
      rhit[i] = valid_q[i] && (key_q[i] == rkey_i);
    end
  end

  // priority encode, lowest index, forward first
  always_comb begin
    match_o = '0;
    for (int i = FlowEntries - 1; i >= 0; i--) begin
      if (rhit[i]) begin
        match_o.hit = 1'b1;
        match_o.rev = 1'b1;
        match_o.idx = IdxW'(i);
      end
    end
    if (|fhit) begin
      match_o.hit = 1'b1;
      match_o.rev = 1'b0;
      for (int i = FlowEntries - 1; i >= 0; i--) begin
        if (fhit[i]) begin
          match_o.idx = IdxW'(i);
        end
      end
    end
  end

endmodule

// ----- rtl/bfst_stats_ram.sv -----
// ----------------------------------------------------------------------------
// bfst_stats_ram
// per-entry statistics memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bfst_stats_ram (
  input  logic                      clk_i,
  input  logic                      rd_i,
  input  logic [bfst_pkg::IdxW-1:0] rd_idx_i,
  output bfst_pkg::stats_t          rd_data_o,
  input  logic                      wr_i,
  input  logic [bfst_pkg::IdxW-1:0] wr_idx_i,
  input  bfst_pkg::stats_t          wr_data_i
);
  import bfst_pkg::*;

  stats_t mem [FlowEntries];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

endmodule

// ----- rtl/bidirectional_flow_stats_table.sv -----
// ----------------------------------------------------------------------------
// bidirectional_flow_stats_table
// flow table keyed by the four-tuple with per-direction saturating counters
// ----------------------------------------------------------------------------
// one packet beat on s_axis carries timestamp, addresses, ports, protocol
// and payload length. the key is compared against every stored entry in
// the forward and swapped direction in the accept cycle; the statistics
// memory is read the same edge. the next cycle modifies the record (counts,
// bytes, duration, or a fresh record on a miss), writes it back and loads
// the result beat into the m_axis output register. the input is held off
// while a packet is in flight: a new packet is accepted only after the
// previous result beat has been taken from the output register.
// a packet with no match and a full table is flagged as dropped with all
// other fields zero and nothing stored.
// reset clears all valid bits and the fill count; the memory needs no
// clearing pass. if m_axis stalls the result holds and s_axis stays low
// on tready until the beat is taken.
// ----------------------------------------------------------------------------
module bidirectional_flow_stats_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // timestamp_us, src_addr, dst_addr, src_port, dst_port, is_udp,
  // payload_bytes, zero fill
  input  logic [bfst_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // entry_index, reverse_dir, new_flow, dropped, flow_is_udp, start_time_us,
  // duration_us, fwd_packets, fwd_bytes, rev_packets, rev_bytes, zero fill
  output logic [bfst_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import bfst_pkg::*;

  state_e state_q, state_d;

  // unpacked input fields
  logic [TsW-1:0]   in_ts;
  logic [AddrW-1:0] in_sa, in_da;
  logic [PortW-1:0] in_sp, in_dp;
  logic             in_udp;
  logic [PayW-1:0]  in_pay;
  assign in_ts  = s_axis_tdata_i[51:0];
  assign in_sa  = s_axis_tdata_i[83:52];
  assign in_da  = s_axis_tdata_i[115:84];
  assign in_sp  = s_axis_tdata_i[131:116];
  assign in_dp  = s_axis_tdata_i[147:132];
  assign in_udp = s_axis_tdata_i[148];
  assign in_pay = s_axis_tdata_i[164:149];

  logic [KeyW-1:0] key, rkey;
  assign key  = {in_sa, in_sp, in_da, in_dp};
  assign rkey = {in_da, in_dp, in_sa, in_sp};

  logic accept;
  assign s_axis_tready_o = (state_q == StIdle);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  match_t mt;
  logic [CntW-1:0] used_q, used_d;
  logic full;
  assign full = (used_q == CntW'(FlowEntries));

  // latched packet for the update cycle
  match_t           mt_q;
  logic [TsW-1:0]   ts_q;
  logic             udp_q;
  logic [PayW-1:0]  pay_q;
  logic             full_q;
  logic [IdxW-1:0]  alloc_q;

  logic key_wr;
  assign key_wr = accept && !mt.hit && !full;

  bfst_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key),
    .rkey_i   (rkey),
    .wr_i     (key_wr),
    .wr_idx_i (used_q[IdxW-1:0]),
    .match_o  (mt)
  );

  stats_t rd_data, wr_data;
  logic   st_wr;

  bfst_stats_ram u_ram (
    .clk_i     (clk_i),
    .rd_i      (accept),
    .rd_idx_i  (mt.idx),
    .rd_data_o (rd_data),
    .wr_i      (st_wr),
    .wr_idx_i  (mt_q.hit ? mt_q.idx : alloc_q),
    .wr_data_i (wr_data)
  );

  // capture packet
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mt_q    <= mt;
      ts_q    <= in_ts;
      udp_q   <= in_udp;
      pay_q   <= in_pay;
      full_q  <= full;
      alloc_q <= used_q[IdxW-1:0];
    end
  end

  // fill count
  assign used_d = key_wr ? used_q + CntW'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      state_q <= StIdle;
    end else begin
      used_q  <= used_d;
      state_q <= state_d;
    end
  end

  // record update
  logic [PktW:0]  pk_sum;
  logic [ByteW:0] by_sum;
  logic [PktW-1:0]  pk_old;
  logic [ByteW-1:0] by_old;
  always_comb begin
    pk_old = mt_q.rev ? rd_data.rpk : rd_data.fpk;
    by_old = mt_q.rev ? rd_data.rby : rd_data.fby;
    pk_sum = {1'b0, pk_old} + (PktW+1)'(1);
    by_sum = {1'b0, by_old} + (ByteW+1)'(pay_q);
    wr_data = rd_data;
    if (mt_q.hit) begin
      wr_data.dur = (ts_q >= rd_data.start) ? ts_q - rd_data.start : '0;
      if (mt_q.rev) begin
        wr_data.rpk = pk_sum[PktW] ? '1 : pk_sum[PktW-1:0];
        wr_data.rby = by_sum[ByteW] ? '1 : by_sum[ByteW-1:0];
      end else begin
        wr_data.fpk = pk_sum[PktW] ? '1 : pk_sum[PktW-1:0];
        wr_data.fby = by_sum[ByteW] ? '1 : by_sum[ByteW-1:0];
      end
    end else begin
      wr_data.udp   = udp_q;
      wr_data.start = ts_q;
      wr_data.dur   = '0;
      wr_data.fpk   = PktW'(1);
      wr_data.fby   = ByteW'(pay_q);
      wr_data.rpk   = '0;
      wr_data.rby   = '0;
    end
  end

  // control
  always_comb begin
    state_d = state_q;
    st_wr   = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StUpdate;
      end
      StUpdate: begin
        st_wr   = mt_q.hit || !full_q;
        state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // output register
  logic [OutDataW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate) begin
      if (!mt_q.hit && full_q) begin
        out_q <= {{(OutDataW-9){1'b0}}, 1'b1, 8'd0};
      end else begin
        out_q <= {6'd0, wr_data.rby, wr_data.rpk, wr_data.fby, wr_data.fpk,
                  wr_data.dur, wr_data.start, wr_data.udp, 1'b0,
                  !mt_q.hit, mt_q.rev && mt_q.hit,
                  OutIdxW'(mt_q.hit ? mt_q.idx : alloc_q)};
      end
    end
  end

  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(FlowEntries)) else $error("fill count overflow");

  // input held off while a packet is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("accept while busy");

  // result is valid in the output state, after the update state that follows accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 m_axis_tvalid_o) else $error("result late");

  // fill count grows only on an allocating accept
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> $past(key_wr)) else $error("bad fill step");
`endif

endmodule

// ----- test/bidirectional_flow_stats_table_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bidirectional_flow_stats_table_chk
// watches both streams, tracks the flow table and compares every result beat
// ----------------------------------------------------------------------------
module bidirectional_flow_stats_table_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [bfst_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [bfst_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            result_cnt_o,
  output int                            drop_cnt_o,
  output int                            rev_cnt_o
);
  import bfst_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0]   rby;
    logic [PktW-1:0]    rpk;
    logic [ByteW-1:0]   fby;
    logic [PktW-1:0]    fpk;
    logic [TsW-1:0]     dur;
    logic [TsW-1:0]     start;
    logic               udp;
    logic               dropped;
    logic               fresh;
    logic               rev;
    logic [OutIdxW-1:0] idx;
  } flow_result_t;

  typedef struct packed {
    logic [PayW-1:0]  pay;
    logic             udp;
    logic [PortW-1:0] dport;
    logic [PortW-1:0] sport;
    logic [AddrW-1:0] dst;
    logic [AddrW-1:0] src;
    logic [TsW-1:0]   ts;
  } packet_t;

  // shadow of the flow table
  logic             shadow_valid [FlowEntries];
  logic [KeyW-1:0]  shadow_key   [FlowEntries];
  stats_t           shadow_stats [FlowEntries];
  int               shadow_used;
  flow_result_t     result_q [$];

  function automatic logic [KeyW-1:0] make_key(logic [AddrW-1:0] a, logic [PortW-1:0] ap,
                                               logic [AddrW-1:0] b, logic [PortW-1:0] bp);
    return {a, ap, b, bp};
  endfunction

  // apply one packet to the shadow table and return the expected result
  function automatic flow_result_t update_flow(packet_t p);
    flow_result_t r;
    int hit;
    logic rev;
    logic [KeyW-1:0] fk, rk;
    stats_t s;
    r = '0;
    hit = -1;
    rev = 1'b0;
    fk = make_key(p.src, p.sport, p.dst, p.dport);
    rk = make_key(p.dst, p.dport, p.src, p.sport);
    for (int i = 0; i < FlowEntries; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == fk) hit = i;
    end
    if (hit < 0) begin
      for (int i = 0; i < FlowEntries; i++) begin
        if (hit < 0 && shadow_valid[i] && shadow_key[i] == rk) begin
          hit = i;
          rev = 1'b1;
        end
      end
    end
    if (hit >= 0) begin
      s = shadow_stats[hit];
      s.dur = (p.ts >= s.start) ? p.ts - s.start : '0;
      if (rev) begin
        if (s.rpk != '1) s.rpk = s.rpk + 1;
        s.rby = ({1'b0, s.rby} + p.pay > {1'b0, {ByteW{1'b1}}}) ? '1 : s.rby + p.pay;
      end else begin
        if (s.fpk != '1) s.fpk = s.fpk + 1;
        s.fby = ({1'b0, s.fby} + p.pay > {1'b0, {ByteW{1'b1}}}) ? '1 : s.fby + p.pay;
      end
      shadow_stats[hit] = s;
    end else if (shadow_used >= FlowEntries) begin
      r.dropped = 1'b1;
      return r;
    end else begin
      hit = shadow_used;
      shadow_used++;
      r.fresh = 1'b1;
      shadow_valid[hit] = 1'b1;
      shadow_key[hit] = fk;
      s.udp = p.udp;
      s.start = p.ts;
      s.dur = '0;
      s.fpk = PktW'(1);
      s.fby = ByteW'(p.pay);
      s.rpk = '0;
      s.rby = '0;
      shadow_stats[hit] = s;
    end
    r.idx = hit[OutIdxW-1:0];
    r.rev = rev;
    r.udp = s.udp;
    r.start = s.start;
    r.dur = s.dur;
    r.fpk = s.fpk;
    r.fby = s.fby;
    r.rpk = s.rpk;
    r.rby = s.rby;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    flow_result_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < FlowEntries; i++) shadow_valid[i] = 1'b0;
      shadow_used = 0;
      result_q.delete();
      fail_cnt_o = 0;
      result_cnt_o = 0;
      drop_cnt_o = 0;
      rev_cnt_o = 0;
    end else begin
      // compare a result beat against the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        a = m_axis_tdata_i[$bits(flow_result_t)-1:0];
        result_cnt_o++;
        if (result_q.size() == 0) begin
          $error("result beat with no packet outstanding");
          fail_cnt_o++;
        end else begin
          e = result_q.pop_front();
          drop_cnt_o += e.dropped;
          rev_cnt_o += e.rev;
          check_field("entry_index", e.idx, a.idx);
          check_field("reverse_dir", e.rev, a.rev);
          check_field("new_flow", e.fresh, a.fresh);
          check_field("dropped", e.dropped, a.dropped);
          check_field("flow_is_udp", e.udp, a.udp);
          check_field("start_time_us", e.start, a.start);
          check_field("duration_us", e.dur, a.dur);
          check_field("fwd_packets", e.fpk, a.fpk);
          check_field("fwd_bytes", e.fby, a.fby);
          check_field("rev_packets", e.rpk, a.rpk);
          check_field("rev_bytes", e.rby, a.rby);
        end
      end
      // predict on each accepted packet beat
      if (s_axis_tvalid_i && s_axis_tready_i)
        result_q.push_back(update_flow(packet_t'(s_axis_tdata_i[$bits(packet_t)-1:0])));
    end
  end

endmodule

// ----- test/bidirectional_flow_stats_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bidirectional_flow_stats_table_tb
// drives packet beats with random gaps and back-pressure into the flow table
// and lets the checker compare each result with its own table shadow
// ----------------------------------------------------------------------------
module bidirectional_flow_stats_table_tb;
  import bfst_pkg::*;

  localparam int MaxCycles = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  int fail_cnt, pending, result_cnt, drop_cnt, rev_cnt;
  int cycle_cnt = 0;
  int sent_cnt = 0;
  bit hold_off_req = 1'b0;
  bit driving_done = 1'b0;

  // small pools of hosts so flows repeat and reverse
  logic [AddrW-1:0] host_pool [8];
  logic [PortW-1:0] port_pool [8];
  logic [TsW-1:0]   clock_us = 52'd1000;

  always #1 clk_i = ~clk_i;

  bidirectional_flow_stats_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  bidirectional_flow_stats_table_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .result_cnt_o    (result_cnt),
    .drop_cnt_o      (drop_cnt),
    .rev_cnt_o       (rev_cnt)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // one packet beat, held until accepted
  task automatic send_packet(logic [TsW-1:0] ts, logic [AddrW-1:0] sa, logic [AddrW-1:0] da,
                             logic [PortW-1:0] sp, logic [PortW-1:0] dp, logic udp,
                             logic [PayW-1:0] pay, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g) @(negedge clk_i);
    s_axis_tdata = '0;
    s_axis_tdata[164:0] = {pay, udp, dp, sp, da, sa, ts};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    sent_cnt++;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // random packet drawn mostly from established flows
  task automatic random_packet(bit wide);
    int a, b;
    logic [TsW-1:0] ts;
    a = $urandom_range(0, 7);
    b = $urandom_range(0, 7);
    clock_us = clock_us + $urandom_range(0, 5000);
    ts = ($urandom_range(0, 9) == 0) ? clock_us - $urandom_range(0, 100000) : clock_us;
    if (wide)
      send_packet(TsW'({$urandom, $urandom}), $urandom, $urandom, PortW'($urandom),
                  PortW'($urandom), 1'($urandom), PayW'($urandom), 1'b1);
    else if ($urandom_range(0, 1))
      send_packet(ts, host_pool[a], host_pool[b], port_pool[a], port_pool[b],
                  1'($urandom), PayW'($urandom), 1'b1);
    else
      send_packet(ts, host_pool[b], host_pool[a], port_pool[b], port_pool[a],
                  1'($urandom), PayW'($urandom), 1'b1);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    int n;
    if (hold_off_req) begin
      m_axis_tready <= 1'b0;
      hold_off_req = 1'b0;
      for (n = 0; n < 60; n++) @(negedge clk_i);
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7) || driving_done;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("bidirectional_flow_stats_table: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      host_pool[i] = $urandom;
      port_pool[i] = PortW'($urandom);
    end
    host_pool[7] = '1;
    port_pool[7] = '1;
    host_pool[6] = '0;
    port_pool[6] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, reverse hits, self flow, old packet, large payloads
    send_packet('0, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    send_packet('1, '0, '0, '0, '0, 1'b1, '1, 1'b0);
    send_packet(52'd100, '1, 32'h0a000001, '1, 16'd80, 1'b1, '1, 1'b0);
    send_packet(52'd150, 32'h0a000001, '1, 16'd80, '1, 1'b0, 16'd10, 1'b0);
    send_packet(52'd50, '1, 32'h0a000001, '1, 16'd80, 1'b0, 16'd7, 1'b0);
    send_packet(52'h5555555555555, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555,
                1'b0, 16'haaaa, 1'b0);
    send_packet(52'haaaaaaaaaaaaa, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa,
                1'b1, 16'h5555, 1'b0);
    send_packet(52'hfffffffffffff, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa,
                1'b0, '1, 1'b0);
    wait_drained();

    // long receiver hold-off while packets keep coming
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) random_packet(1'b0);
    wait_drained();

    // random traffic; about one packet in six is wide with random fields, and these fill the table to drops
    for (int i = 0; i < 800; i++) random_packet($urandom_range(0, 5) == 0);

    driving_done = 1'b1;
    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("sent %0d packets, %0d results, %0d dropped on a full table, %0d reverse hits",
             sent_cnt, result_cnt, drop_cnt, rev_cnt);
    if (fail_cnt == 0 && pending == 0)
      $display("bidirectional_flow_stats_table: match");
    else
      $display("bidirectional_flow_stats_table: mismatch");
    $finish;
  end

endmodule
